// ----- rtl/mts_pkg.sv -----
// mts_pkg: opcodes, status codes and default sizes for the min tracking stack.
// Standalone package with no dependencies; used by min_tracking_stack_core.
package mts_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DEFAULT_VALUE_BITS  = 32;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;

    localparam opcode_t OP_PUSH = 2'd0;
    localparam opcode_t OP_POP  = 2'd1;
    localparam opcode_t OP_READ = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

// ----- rtl/min_tracking_stack_core.sv -----
// Stack of signed values that reports its minimum with every word, using the
// encoded-difference scheme (a push of a new minimum x stores 2x - min).
// The top entry and the minimum live in registers; entries below the top are
// kept in one RAM (mts_ram). A push, a read and any pop that leaves the stack
// empty or hits an empty stack put their result in the output register in the
// cycle after acceptance. A pop that leaves entries behind first reads the new
// top entry through the RAM's registered read port, then loads the output register
// once that is free; no other command is accepted while the pop is in flight.
// A new command is accepted while a result waits in the output register only
// if that result is taken in the same cycle. The RAM needs no clearing after
// reset: only entries below the fill count are ever read.
module min_tracking_stack_core #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH,
    parameter int VALUE_BITS  = mts_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  mts_pkg::opcode_t             opcode,
    input  logic signed [VALUE_BITS-1:0] push_value,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic signed [VALUE_BITS-1:0] popped_value,
    output logic signed [VALUE_BITS-1:0] top_value,
    output logic signed [VALUE_BITS-1:0] minimum_value,
    output logic                         is_empty,
    output mts_pkg::status_t             status
);
    import mts_pkg::*;

    localparam int ENTRY_W = VALUE_BITS + 2;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef logic signed [ENTRY_W-1:0]    entry_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;

    function automatic entry_t widen(input value_t v);
        widen = {{2{v[VALUE_BITS-1]}}, v};
    endfunction

    // an entry below the minimum stands for the minimum itself
    function automatic value_t decode(input entry_t t, input value_t m);
        decode = (t < widen(m)) ? m : t[VALUE_BITS-1:0];
    endfunction

    // stack state
    logic [CNT_W-1:0] count_reg, count_next;
    entry_t           tos_reg, tos_next;
    value_t           min_reg, min_next;
    logic             pend_reg, pend_next;
    value_t           popped_pend_reg, popped_pend_next;

    // output register
    logic    rsp_valid_reg, rsp_valid_next;
    value_t  popped_value_reg, popped_value_next;
    value_t  top_value_reg, top_value_next;
    value_t  minimum_value_reg, minimum_value_next;
    logic    is_empty_reg, is_empty_next;
    status_t status_reg, status_next;

    // RAM port signals
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    entry_t            ram_rd_data;

    logic             out_free;
    logic             accept;
    logic             finish;
    logic             is_full;
    logic             is_zero;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] count_m2;
    entry_t           x_e;
    entry_t           min_e;
    entry_t           push_enc;
    entry_t           restored_min;
    logic             push_lt;
    logic             tos_lt;
    value_t           cur_top;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = pend_reg || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign finish    = pend_reg && out_free;

    assign is_zero  = (count_reg == '0);
    assign is_full  = (count_reg >= CNT_W'(STACK_DEPTH));
    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);

    assign x_e          = widen(push_value);
    assign min_e        = widen(min_reg);
    assign push_lt      = (push_value < min_reg);
    assign push_enc     = push_lt ? ((x_e <<< 1) - min_e) : x_e;
    assign tos_lt       = (tos_reg < min_e);
    assign restored_min = (min_e <<< 1) - tos_reg;
    assign cur_top      = decode(tos_reg, min_reg);

    always_comb
    begin
        count_next         = count_reg;
        tos_next           = tos_reg;
        min_next           = min_reg;
        pend_next          = pend_reg;
        popped_pend_next   = popped_pend_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        popped_value_next  = popped_value_reg;
        top_value_next     = top_value_reg;
        minimum_value_next = minimum_value_reg;
        is_empty_next      = is_empty_reg;
        status_next        = status_reg;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = count_m1[ADDR_W-1:0];
        ram_wr_data        = tos_reg;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = count_m2[ADDR_W-1:0];

        if (finish)
        begin
            // new top entry has come out of the ram
            tos_next           = ram_rd_data;
            pend_next          = 1'b0;
            rsp_valid_next     = 1'b1;
            popped_value_next  = popped_pend_reg;
            top_value_next     = decode(ram_rd_data, min_reg);
            minimum_value_next = min_reg;
            is_empty_next      = 1'b0;
            status_next        = ST_OK;
        end
        else if (accept)
        begin
            rsp_valid_next     = 1'b1;
            popped_value_next  = '0;
            top_value_next     = cur_top;
            minimum_value_next = min_reg;
            is_empty_next      = is_zero;
            status_next        = ST_OK;
            if (is_zero)
            begin
                top_value_next     = '0;
                minimum_value_next = '0;
            end
            unique case (opcode)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        top_value_next = push_value;
                        is_empty_next  = 1'b0;
                        count_next     = count_reg + CNT_W'(1);
                        if (is_zero)
                        begin
                            tos_next           = x_e;
                            min_next           = push_value;
                            minimum_value_next = push_value;
                        end
                        else
                        begin
                            // old top moves down into the ram
                            ram_wr_en          = 1'b1;
                            tos_next           = push_enc;
                            min_next           = push_lt ? push_value : min_reg;
                            minimum_value_next = push_lt ? push_value : min_reg;
                        end
                    end
                end
                OP_POP:
                begin
                    if (is_zero)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_m1;
                        if (tos_lt)
                        begin
                            min_next = restored_min[VALUE_BITS-1:0];
                        end
                        if (count_reg == CNT_W'(1))
                        begin
                            popped_value_next  = cur_top;
                            top_value_next     = '0;
                            minimum_value_next = '0;
                            is_empty_next      = 1'b1;
                        end
                        else
                        begin
                            // result waits for the entry below the top
                            ram_rd_en        = 1'b1;
                            pend_next        = 1'b1;
                            popped_pend_next = cur_top;
                            rsp_valid_next   = rsp_valid_reg && rsp_stall;
                        end
                    end
                end
                default:
                begin
                    if (is_zero)
                    begin
                        status_next = ST_EMPTY;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            min_reg       <= min_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg           <= tos_next;
        popped_pend_reg   <= popped_pend_next;
        popped_value_reg  <= popped_value_next;
        top_value_reg     <= top_value_next;
        minimum_value_reg <= minimum_value_next;
        is_empty_reg      <= is_empty_next;
        status_reg        <= status_next;
    end

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rsp_valid     = rsp_valid_reg;
    assign popped_value  = popped_value_reg;
    assign top_value     = top_value_reg;
    assign minimum_value = minimum_value_reg;
    assign is_empty      = is_empty_reg;
    assign status        = status_reg;

endmodule

// ----- rtl/mts_ram.sv -----
// mts_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds while rd_en is low.
module mts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench for min_tracking_stack_core: drives push, pop and read words and checks
// every response against a local model of the encoded-difference minimum stack.
// Depends on mts_pkg for the opcode and status codes.
module testbench;

    import mts_pkg::*;

    localparam int VW          = DEFAULT_VALUE_BITS;
    localparam int DEPTH       = DEFAULT_STACK_DEPTH;
    localparam int HOLD_CYCLES = 120;
    localparam int STUCK_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;
    // opcode 3 is unused and must act as a read
    localparam opcode_t OP_SPARE = 2'd3;

    typedef struct {
        logic signed [VW-1:0] popped;
        logic signed [VW-1:0] top;
        logic signed [VW-1:0] minimum;
        logic                 empty;
        status_t              status;
    } stack_view_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cmd_valid  = 1'b0;
    logic                 cmd_stall;
    opcode_t              opcode     = OP_PUSH;
    logic signed [VW-1:0] push_value = '0;
    logic                 rsp_valid;
    logic                 rsp_stall  = 1'b0;
    logic signed [VW-1:0] popped_value;
    logic signed [VW-1:0] top_value;
    logic signed [VW-1:0] minimum_value;
    logic                 is_empty;
    status_t              status;

    // model state: encoded entries need two bits more than a value
    longint      model_entries[DEPTH];
    int unsigned model_fill = 0;
    longint      model_min  = 0;

    stack_view_t pending_views[$];
    int          error_count  = 0;
    int          stuck_cycles = 0;
    bit          idle_on      = 1'b1;
    bit          hold_active  = 1'b0;
    event        hold_go;

    min_tracking_stack_core #(
        .STACK_DEPTH(DEPTH),
        .VALUE_BITS (VW)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .opcode       (opcode),
        .push_value   (push_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .popped_value (popped_value),
        .top_value    (top_value),
        .minimum_value(minimum_value),
        .is_empty     (is_empty),
        .status       (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic stack_view_t apply_stack_op(opcode_t op, logic signed [VW-1:0] raw);
        stack_view_t v;
        longint      x;
        longint      t;
        v.popped = '0;
        v.status = ST_OK;
        x = longint'(raw);
        case (op)
            OP_PUSH:
            begin
                if (model_fill >= DEPTH)
                    v.status = ST_FULL;
                else if (model_fill == 0)
                begin
                    model_entries[0] = x;
                    model_min = x;
                    model_fill = 1;
                end
                else
                begin
                    if (x < model_min)
                    begin
                        model_entries[model_fill] = 2 * x - model_min;
                        model_min = x;
                    end
                    else
                        model_entries[model_fill] = x;
                    model_fill++;
                end
            end
            OP_POP:
            begin
                if (model_fill == 0)
                    v.status = ST_EMPTY;
                else
                begin
                    t = model_entries[model_fill - 1];
                    model_fill--;
                    // an entry below the minimum marks where the minimum was set
                    if (t < model_min)
                    begin
                        v.popped = VW'(model_min);
                        model_min = 2 * model_min - t;
                    end
                    else
                        v.popped = VW'(t);
                end
            end
            default:
            begin
                if (model_fill == 0)
                    v.status = ST_EMPTY;
            end
        endcase
        if (model_fill == 0)
        begin
            v.top = '0;
            v.minimum = '0;
            v.empty = 1'b1;
        end
        else
        begin
            t = model_entries[model_fill - 1];
            v.top = VW'((t < model_min) ? model_min : t);
            v.minimum = VW'(model_min);
            v.empty = 1'b0;
        end
        return v;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(VW-1){1'b0}}};
            1: return {1'b0, {(VW-1){1'b1}}};
            2, 3, 4, 5: return int'($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // offer one word and hold it until accepted; caller returns at the accepting edge
    task automatic send_word(opcode_t op, logic signed [VW-1:0] value);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 9)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid  <= 1'b1;
        opcode     <= op;
        push_value <= value;
        do
            @(posedge clk);
        while (cmd_stall);
        pending_views.push_back(apply_stack_op(op, value));
    endtask

    task automatic push_word(logic signed [VW-1:0] value);
        send_word(OP_PUSH, value);
    endtask

    task automatic pop_word();
        send_word(OP_POP, $urandom);
    endtask

    // response checker
    always @(posedge clk)
    begin
        stack_view_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_views.size() == 0)
                note_error("response word with nothing outstanding");
            else
            begin
                want = pending_views.pop_front();
                if (popped_value !== want.popped || top_value !== want.top ||
                    minimum_value !== want.minimum || is_empty !== want.empty ||
                    status !== want.status)
                    note_error($sformatf(
                        {"mismatch: exp pop %0d top %0d min %0d empty %0b st %0d, ",
                         "got pop %0d top %0d min %0d empty %0b st %0d"},
                        want.popped, want.top, want.minimum, want.empty, want.status,
                        popped_value, top_value, minimum_value, is_empty, status));
            end
        end
    end

    // receiver stall: random idling, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_active)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= idle_on && ($urandom_range(0, 99) < 9);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            @(posedge clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic test_empty_stack();
        send_word(OP_READ, $urandom);
        pop_word();
        send_word(OP_SPARE, $urandom);
    endtask

    task automatic test_value_extremes();
        push_word({1'b0, {(VW-1){1'b1}}});
        // most negative value under the largest minimum gives the widest encoding
        push_word({1'b1, {(VW-1){1'b0}}});
        send_word(OP_READ, $urandom);
        send_word(OP_SPARE, $urandom);
        push_word({1'b1, {(VW-1){1'b0}}});
        pop_word();
        pop_word();
        pop_word();
    endtask

    task automatic test_minimum_chain();
        push_word(5);
        push_word(3);
        push_word(3);
        push_word(-7);
        push_word(-100);
        repeat (5) pop_word();
    endtask

    task automatic test_fill_under_backpressure();
        -> hold_go;
        repeat (DEPTH + 2) push_word(pick_value());
        send_word(OP_READ, $urandom);
        repeat (DEPTH + 1) pop_word();
    endtask

    task automatic test_random_mix(int count, int push_pct, bit idling);
        int      r;
        opcode_t op;
        idle_on = idling;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                op = OP_PUSH;
            else if (r < push_pct + (100 - push_pct) * 3 / 4)
                op = OP_POP;
            else
                op = $urandom_range(0, 1) ? OP_READ : OP_SPARE;
            send_word(op, (op == OP_PUSH) ? pick_value() : $urandom);
        end
        idle_on = 1'b1;
    endtask

    task automatic finish_run();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_views.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_stack();
        test_value_extremes();
        test_minimum_chain();
        test_fill_under_backpressure();
        test_random_mix(70, 75, 1'b1);
        test_random_mix(70, 55, 1'b1);
        test_random_mix(60, 30, 1'b0);
        test_random_mix(50, 50, 1'b1);
        finish_run();
    end

endmodule

// ----- files.f -----
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/min_tracking_stack_core.sv
tb/sv/testbench.sv
